/* rtl/core/shortest_job_first_tick_scheduler_top_assert.svh */
// Assertion macros shared by the scheduler's checker.
`ifndef SHORTEST_JOB_FIRST_TICK_SCHEDULER_TOP_ASSERT_SVH
`define SHORTEST_JOB_FIRST_TICK_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SJF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SJF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

/* rtl/core/sjf_pkg.sv */
// Shared types and constants of the shortest-job-first tick scheduler.
`default_nettype none

package sjf_pkg;

  localparam int unsigned IDX_BITS       = 4;
  localparam int unsigned ARR_BITS       = 16;
  localparam int unsigned BURST_BITS     = 16;
  localparam int unsigned CNT_BITS       = 16;
  localparam int unsigned ACT_BITS       = 5;
  localparam int unsigned NUM_ENTRIES_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 16;

  localparam logic [CNT_BITS-1:0] CNT_MAX    = '1;
  localparam logic [ACT_BITS-1:0] ACTIVE_RST = 5'd16;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    action_t                 action;
    logic [IDX_BITS-1:0]     proc_index;
    logic [ARR_BITS-1:0]     arrival_time;
    logic [BURST_BITS-1:0]   burst_length;
  } in_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]     selected_proc;
    logic                    idle;
    logic                    finished;
    logic [CNT_BITS-1:0]     wait_out;
    logic [CNT_BITS-1:0]     turnaround_out;
  } out_item_t;

  typedef struct packed {
    logic [ARR_BITS-1:0]     arrival;
    logic [BURST_BITS-1:0]   orig_burst;
    logic [BURST_BITS-1:0]   rem_burst;
    logic [CNT_BITS-1:0]     wait_cnt;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/sjf_table.sv */
// Process table memory with per-entry valid bits; invalid entries read as zero.
`default_nettype none

module sjf_table #(
  parameter int unsigned NUM_ENTRIES = sjf_pkg::NUM_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sjf_pkg::tbl_ctl_t                ctl,
  input  logic [$clog2(NUM_ENTRIES)-1:0]   wr_addr,
  input  sjf_pkg::entry_t                  wr_data,
  input  logic [$clog2(NUM_ENTRIES)-1:0]   rd_addr,
  output sjf_pkg::entry_t                  rd_data
);
  import sjf_pkg::*;

  logic [NUM_ENTRIES-1:0] vld_r;
  entry_t                 mem_r [NUM_ENTRIES];
  entry_t                 rd_q_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

/* rtl/core/sjf_scan.sv */
// Shared scan unit: readiness test, minimum-burst compare and wait update per entry.
`default_nettype none

module sjf_scan #(
  parameter int unsigned NUM_ENTRIES = sjf_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned TIME_BITS   = sjf_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             ent_vld,
  input  logic [$clog2(NUM_ENTRIES)-1:0]   ent_idx,
  input  sjf_pkg::entry_t                  ent,
  input  logic [TIME_BITS-1:0]             cur_time,
  output logic                             wb_en,
  output sjf_pkg::entry_t                  wb_ent,
  output logic                             found,
  output logic [$clog2(NUM_ENTRIES)-1:0]   best_idx,
  output sjf_pkg::entry_t                  best_ent
);
  import sjf_pkg::*;

  localparam int unsigned AW   = $clog2(NUM_ENTRIES);
  localparam int unsigned CMPW = (TIME_BITS > ARR_BITS) ? TIME_BITS : ARR_BITS;

  logic            found_r;
  logic [AW-1:0]   best_idx_r;
  entry_t          best_ent_r;
  logic            arrived;
  logic            ready;
  logic            better;

  assign arrived = CMPW'(ent.arrival) <= CMPW'(cur_time);
  assign ready   = ent_vld && arrived && (ent.rem_burst != '0);
  assign better  = !found_r || (ent.orig_burst < best_ent_r.orig_burst);

  always_comb begin
    wb_ent = ent;
    if (ent.wait_cnt != CNT_MAX) begin
      wb_ent.wait_cnt = ent.wait_cnt + CNT_BITS'(1);
    end
  end

  assign wb_en = ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (start) begin
      found_r <= 1'b0;
    end else if (ready && better) begin
      found_r <= 1'b1;
    end
  end

  // The winner keeps its wait from before this tick's increment.
  always_ff @(posedge clk) begin
    if (ready && better) begin
      best_idx_r <= ent_idx;
      best_ent_r <= ent;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best_ent = best_ent_r;

endmodule

`default_nettype wire

/* rtl/core/shortest_job_first_tick_scheduler_top.sv */
// Top level of the preemptive shortest-job-first tick scheduler.
//
//   Channel   Ports                              Beat contents
//   input     in_valid, in_stall, in_data        action, index, arrival, burst
//   result    out_valid, out_stall, out_data     selected entry, flags, statistics
//   config    cfg_wr_en, cfg_wr_data             active entry count
//
// A clear or load passes the done state; a read passes read-wait and done.
// A tick scans min(active count, NUM_ENTRIES) entries, then passes fix and
// done; the scan unit reads one table entry per cycle via the single read port.
// Reset is synchronous; it clears the time, the table and the output valid flag.
// in_stall stays high while an item is in work, and a finished result waits in
// front of the output register while out_stall holds the previous beat.
`default_nettype none

module shortest_job_first_tick_scheduler_top #(
  parameter int unsigned NUM_ENTRIES = sjf_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned TIME_BITS   = sjf_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sjf_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sjf_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [sjf_pkg::ACT_BITS-1:0]   cfg_wr_data
);
  import sjf_pkg::*;

  localparam int unsigned AW = $clog2(NUM_ENTRIES);
  localparam int unsigned CW = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned LW = (CW > ACT_BITS) ? CW : ACT_BITS;
  localparam int unsigned IW = (AW > IDX_BITS) ? AW : IDX_BITS;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_FIX    = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [ACT_BITS-1:0]   active_r;
  logic [TIME_BITS-1:0]  time_r, time_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  p_vld_r;
  logic [AW-1:0]         p_idx_r;
  logic                  idx_ok_r;
  out_item_t             res_r, res_nxt;
  logic                  out_vld_r, out_vld_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_acc;
  logic [IW-1:0]         idx_ext;
  logic                  idx_ok;
  logic [LW-1:0]         act_ext;
  logic [LW-1:0]         lim_l;
  logic [CW-1:0]         lim;
  logic                  iss;
  logic                  slot_free;
  logic                  scan_start;

  tbl_ctl_t              tbl_ctl;
  logic [AW-1:0]         wr_addr;
  entry_t                wr_data;
  logic [AW-1:0]         rd_addr;
  entry_t                rd_ent;

  logic                  wb_en;
  entry_t                wb_ent;
  logic                  found;
  logic [AW-1:0]         best_idx;
  entry_t                best_ent;
  logic [IW-1:0]         sel_ext;
  logic [CNT_BITS:0]     tat_sum;
  logic [CNT_BITS-1:0]   tat;

  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign idx_ext   = IW'(in_data.proc_index);
  assign idx_ok    = {1'b0, idx_ext} < (IW + 1)'(NUM_ENTRIES);
  assign act_ext   = LW'(active_r);
  assign lim_l     = (act_ext > LW'(NUM_ENTRIES)) ? LW'(NUM_ENTRIES) : act_ext;
  assign lim       = lim_l[CW-1:0];
  assign iss       = (state_r == ST_SCAN) && (cnt_r < lim);
  assign slot_free = !out_vld_r || !out_stall;
  assign sel_ext   = IW'(best_idx);
  assign tat_sum   = {1'b0, rd_ent.wait_cnt} + {1'b0, rd_ent.orig_burst};
  assign tat       = tat_sum[CNT_BITS] ? CNT_MAX : tat_sum[CNT_BITS-1:0];
  assign rd_addr   = iss ? cnt_r[AW-1:0] : idx_ext[AW-1:0];

  always_comb begin
    tbl_ctl.clr   = in_acc && (in_data.action == ACT_CLEAR);
    tbl_ctl.rd_en = iss || (in_acc && (in_data.action == ACT_READ));
    tbl_ctl.wr_en = 1'b0;
    wr_addr       = idx_ext[AW-1:0];
    wr_data.arrival    = in_data.arrival_time;
    wr_data.orig_burst = in_data.burst_length;
    wr_data.rem_burst  = in_data.burst_length;
    wr_data.wait_cnt   = '0;
    if (state_r == ST_SCAN) begin
      tbl_ctl.wr_en = wb_en;
      wr_addr       = p_idx_r;
      wr_data       = wb_ent;
    end else if (state_r == ST_FIX) begin
      tbl_ctl.wr_en     = found;
      wr_addr           = best_idx;
      wr_data           = best_ent;
      wr_data.rem_burst = best_ent.rem_burst - BURST_BITS'(1);
    end else begin
      tbl_ctl.wr_en = in_acc && (in_data.action == ACT_LOAD) && idx_ok;
    end
  end

  sjf_table #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_ent)
  );

  sjf_scan #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .ent_vld  (p_vld_r),
    .ent_idx  (p_idx_r),
    .ent      (rd_ent),
    .cur_time (time_r),
    .wb_en    (wb_en),
    .wb_ent   (wb_ent),
    .found    (found),
    .best_idx (best_idx),
    .best_ent (best_ent)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    time_nxt     = time_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_data_nxt = out_data_r;
    scan_start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          cnt_nxt = '0;
          case (in_data.action)
            ACT_CLEAR: begin
              time_nxt  = '0;
              state_nxt = ST_DONE;
            end
            ACT_LOAD: begin
              state_nxt = ST_DONE;
            end
            ACT_TICK: begin
              scan_start = 1'b1;
              state_nxt  = ST_SCAN;
            end
            ACT_READ: begin
              state_nxt = ST_RDWAIT;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (iss) begin
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (found) begin
          res_nxt.selected_proc = sel_ext[IDX_BITS-1:0];
          res_nxt.finished      = (best_ent.rem_burst == BURST_BITS'(1));
        end else begin
          res_nxt.idle = 1'b1;
        end
        if (time_r != {TIME_BITS{1'b1}}) begin
          time_nxt = time_r + TIME_BITS'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_RDWAIT: begin
        if (idx_ok_r) begin
          res_nxt.wait_out       = rd_ent.wait_cnt;
          res_nxt.turnaround_out = tat;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      active_r  <= ACTIVE_RST;
      time_r    <= '0;
      cnt_r     <= '0;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      time_r    <= time_nxt;
      cnt_r     <= cnt_nxt;
      p_vld_r   <= iss;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r    <= cnt_r[AW-1:0];
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      idx_ok_r <= idx_ok;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/sjf_checker.sv */
// Port-level checker for the scheduler top level, with its bind statement.
`default_nettype none

`include "shortest_job_first_tick_scheduler_top_assert.svh"

module sjf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input sjf_pkg::out_item_t   out_data
);
  import sjf_pkg::*;

  `SJF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  `SJF_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  `SJF_ASSERT_IMP(a_idle_quiet, out_valid && out_data.idle, (out_data.selected_proc == '0) && !out_data.finished && (out_data.wait_out == '0) && (out_data.turnaround_out == '0))

  `SJF_ASSERT_IMP(a_tat_covers_wait, out_valid, out_data.turnaround_out >= out_data.wait_out)

endmodule

bind shortest_job_first_tick_scheduler_top sjf_checker u_sjf_checker (.*);

`default_nettype wire

/* verif/sjf_tick_checker.sv */
`timescale 1ns / 100ps
// Checker that tracks the scheduler table from observed beats and compares each result beat.
module sjf_tick_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  sjf_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  sjf_pkg::out_item_t           out_data,
  input  logic                         cfg_wr_en,
  input  logic [sjf_pkg::ACT_BITS-1:0] cfg_wr_data,
  output int unsigned                  fault_count,
  output int unsigned                  results_owed
);
  import sjf_pkg::*;

  localparam int unsigned TABLE_DEPTH = NUM_ENTRIES_DEF;
  localparam int unsigned LOG_LIMIT   = 40;

  logic [ACT_BITS-1:0]      active_cnt;
  logic [ARR_BITS-1:0]      arrival_tbl [TABLE_DEPTH];
  logic [BURST_BITS-1:0]    burst_tbl   [TABLE_DEPTH];
  logic [BURST_BITS-1:0]    left_tbl    [TABLE_DEPTH];
  logic [CNT_BITS-1:0]      wait_tbl    [TABLE_DEPTH];
  logic [TIME_BITS_DEF-1:0] sched_now;
  out_item_t                owed_q[$];
  out_item_t                owed_head;

  initial begin
    fault_count  = 0;
    results_owed = 0;
  end

  task automatic log_fault(string msg);
    if (fault_count < LOG_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
    fault_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      log_fault($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic void wipe_table();
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      arrival_tbl[i] = '0;
      burst_tbl[i]   = '0;
      left_tbl[i]    = '0;
      wait_tbl[i]    = '0;
    end
    sched_now = '0;
  endfunction

  function automatic bit entry_ready(int unsigned i);
    return (arrival_tbl[i] <= sched_now) && (left_tbl[i] != '0);
  endfunction

  function automatic out_item_t sched_step(in_item_t item);
    out_item_t           res;
    int unsigned         span;
    int unsigned         best;
    bit                  found;
    logic [CNT_BITS:0]   total;
    res   = '0;
    best  = 0;
    found = 1'b0;
    case (item.action)
      ACT_CLEAR: wipe_table();
      ACT_LOAD: begin
        arrival_tbl[item.proc_index] = item.arrival_time;
        burst_tbl[item.proc_index]   = item.burst_length;
        left_tbl[item.proc_index]    = item.burst_length;
        wait_tbl[item.proc_index]    = '0;
      end
      ACT_TICK: begin
        span = (32'(active_cnt) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(active_cnt);
        for (int unsigned i = 0; i < span; i++) begin
          if (entry_ready(i) && (!found || burst_tbl[i] < burst_tbl[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          for (int unsigned i = 0; i < span; i++) begin
            if (i != best && entry_ready(i) && wait_tbl[i] != CNT_MAX) begin
              wait_tbl[i]++;
            end
          end
          left_tbl[best]--;
          res.selected_proc = best[IDX_BITS-1:0];
          res.finished      = (left_tbl[best] == '0);
        end else begin
          res.idle = 1'b1;
        end
        if (sched_now != '1) begin
          sched_now++;
        end
      end
      ACT_READ: begin
        total = {1'b0, wait_tbl[item.proc_index]} + {1'b0, burst_tbl[item.proc_index]};
        res.wait_out       = wait_tbl[item.proc_index];
        res.turnaround_out = total[CNT_BITS] ? CNT_MAX : total[CNT_BITS-1:0];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      active_cnt = ACTIVE_RST;
      wipe_table();
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          log_fault($sformatf("result beat %h arrived with no result owed", out_data));
        end else begin
          owed_head = owed_q.pop_front();
          check_field("selected_proc", 32'(out_data.selected_proc),
                      32'(owed_head.selected_proc));
          check_field("idle", 32'(out_data.idle), 32'(owed_head.idle));
          check_field("finished", 32'(out_data.finished), 32'(owed_head.finished));
          check_field("wait_out", 32'(out_data.wait_out), 32'(owed_head.wait_out));
          check_field("turnaround_out", 32'(out_data.turnaround_out),
                      32'(owed_head.turnaround_out));
        end
      end
      if (cfg_wr_en) begin
        active_cnt = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        owed_q = {owed_q, sched_step(in_data)};
      end
    end
    results_owed <= owed_q.size();
  end

endmodule

/* verif/shortest_job_first_tick_scheduler_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top that drives directed, random and saturation traffic into the scheduler.
module shortest_job_first_tick_scheduler_top_tb;
  import sjf_pkg::*;

  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_BEATS = 75;
  localparam int unsigned SAT_TICKS   = 20;
  localparam int unsigned DRAIN_TAIL  = 24;
  localparam int unsigned CFG_PAUSE   = 4;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  in_item_t            in_data     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  out_item_t           out_data;
  logic                cfg_wr_en   = 1'b0;
  logic [ACT_BITS-1:0] cfg_wr_data = '0;

  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         sched_clock    = 0;
  int unsigned         beats_sent     = 0;
  int unsigned         fault_count;
  int unsigned         results_owed;
  logic [ACT_BITS-1:0] active_sel     = ACTIVE_RST;

  int unsigned phase_active [PHASE_COUNT] = '{16, 1, 31, 5, 0, 16, 0, 2};
  int unsigned idle_mode    [4]           = '{0, 50, 0, 7};
  int unsigned stall_mode   [4]           = '{0, 0, 50, 7};

  shortest_job_first_tick_scheduler_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  sjf_tick_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fault_count  (fault_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic issue(action_t act, int unsigned idx, int unsigned arr, int unsigned burst);
    in_item_t item;
    item.action       = act;
    item.proc_index   = idx[IDX_BITS-1:0];
    item.arrival_time = arr[ARR_BITS-1:0];
    item.burst_length = burst[BURST_BITS-1:0];
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (act == ACT_CLEAR) begin
      sched_clock = 0;
    end else if (act == ACT_TICK) begin
      sched_clock++;
    end
  endtask

  task automatic settle(int unsigned tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_active(logic [ACT_BITS-1:0] value);
    active_sel  = value;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly a well-formed job set: optional clear, loads near the current time, ticks, reads.
  task automatic run_episode();
    int unsigned span;
    int unsigned pick;
    span = (active_sel == 0 || active_sel > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF : active_sel;
    if ($urandom_range(3) == 0) begin
      issue(ACT_CLEAR, $urandom, $urandom, $urandom);
    end
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        issue(ACT_LOAD, $urandom, $urandom, $urandom);
      end else begin
        issue(ACT_LOAD, $urandom_range(span - 1), sched_clock + $urandom_range(0, 8),
              (pick == 1) ? 0 : $urandom_range(1, 12));
      end
    end
    repeat ($urandom_range(3, 25)) begin
      issue(ACT_TICK, $urandom, $urandom, $urandom);
    end
    repeat ($urandom_range(1, 4)) begin
      issue(ACT_READ, ($urandom_range(4) == 0) ? $urandom : $urandom_range(span - 1),
            $urandom, $urandom);
    end
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        issue(action_t'($urandom_range(3)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int unsigned phase_goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first clear defines every table entry before anything reads one.
    issue(ACT_CLEAR, '1, '1, '1);
    issue(ACT_TICK, '0, '0, '0);
    issue(ACT_READ, 15, '0, '0);
    issue(ACT_LOAD, 0, '0, '0);
    issue(ACT_LOAD, 15, '1, '1);
    issue(ACT_LOAD, 1, 0, 3);
    issue(ACT_LOAD, 2, 0, 3);
    issue(ACT_LOAD, 3, 3, 1);
    repeat (5) issue(ACT_TICK, '0, '0, '0);
    issue(ACT_LOAD, 2, 0, 2);
    repeat (4) issue(ACT_TICK, '1, '1, '1);
    for (int i = 0; i < 4; i++) begin
      issue(ACT_READ, i, '0, '0);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle(CFG_PAUSE);
      send_idle_pct  = idle_mode[p % 4];
      recv_stall_pct = stall_mode[p % 4];
      set_active((p == 6) ? ACT_BITS'($urandom_range(1, 16)) : ACT_BITS'(phase_active[p]));
      phase_goal = beats_sent + PHASE_BEATS;
      run_episode();
      settle(0);
      while (beats_sent < phase_goal) run_episode();
    end

    // Short run with the longest bursts that drives turnaround into saturation.
    settle(CFG_PAUSE);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_active(5'd3);
    issue(ACT_CLEAR, '0, '0, '0);
    for (int i = 0; i < 3; i++) begin
      issue(ACT_LOAD, i, '0, '1);
    end
    repeat (SAT_TICKS) issue(ACT_TICK, '0, '0, '0);
    issue(ACT_LOAD, 1, '1, 1);
    repeat (2) issue(ACT_TICK, '0, '0, '0);
    for (int i = 0; i < 3; i++) begin
      issue(ACT_READ, i, '0, '0);
    end

    settle(DRAIN_TAIL);
    if (fault_count == 0 && results_owed == 0) begin
      $display("shortest_job_first_tick_scheduler_top_tb passed");
    end else begin
      $display("shortest_job_first_tick_scheduler_top_tb failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("shortest_job_first_tick_scheduler_top_tb failed");
    $finish;
  end

endmodule
